>>> src/assert_macros.svh
// Assertion helpers for the RTL files; mrt_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define MRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The expression must never be true outside reset.
`define MRT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `MRT_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

>>> src/mrt_pkg.sv
`default_nettype none

package mrt_pkg;

    localparam int MAC_W    = 48;
    localparam int BRIDGE_W = 8;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 7;
    localparam int CMD_W    = 2;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 48;

    localparam int TABLE_ENTRIES_DEF  = 64;
    localparam int BRIDGE_ID_BITS_DEF = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SWEEP  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

>>> src/mac_request_table_with_aging.sv
// Request table keyed by MAC address and bridge index, with expiry aging.
// Input channel s_axis: tuser carries the command (lookup, insert or refresh,
// sweep); tdata carries the key, the expiry for an insert and the current
// time for a sweep. Output channel m_axis: one result item per input item,
// carrying the hit flag, the stored expiry, the dropped flag and the number
// of entries removed.
// Every command but the unused one walks the whole table memory, one entry
// per cycle through its single read port; the unused command skips the walk.
// The next item is accepted only once the result of the last one has been
// loaded into the output register.
// After reset the block clears every table entry, with s_axis_tready low,
// before it accepts the first item.
// The result waits in an output register while m_axis_tready is low; the
// next item is still accepted and walked, and its result is held back only
// until that register is free.
`default_nettype none

module mac_request_table_with_aging #(
    parameter int TABLE_ENTRIES  = mrt_pkg::TABLE_ENTRIES_DEF,
    parameter int BRIDGE_ID_BITS = mrt_pkg::BRIDGE_ID_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // mac_addr[47:0], bridge_id[55:48], expiry_time[87:56], now_time[119:88]
    input  wire logic [mrt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [mrt_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // hit[0], stored_expiry[32:1], dropped[33], removed_count[40:34], zero fill
    output logic      [mrt_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int WW = 1 + mrt_pkg::MAC_W + BRIDGE_ID_BITS + mrt_pkg::TIME_W;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [WW-1:0] mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [WW-1:0] mem_rd_data;

    mrt_ctrl #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .BRIDGE_ID_BITS (BRIDGE_ID_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_mem_wr_en    (mem_wr_en),
        .o_mem_wr_addr  (mem_wr_addr),
        .o_mem_wr_data  (mem_wr_data),
        .o_mem_rd_addr  (mem_rd_addr),
        .i_mem_rd_data  (mem_rd_data)
    );

    mrt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

>>> src/mrt_mem.sv
`default_nettype none

module mrt_mem #(
    parameter int DEPTH = mrt_pkg::TABLE_ENTRIES_DEF,
    parameter int WIDTH = 1 + mrt_pkg::MAC_W + mrt_pkg::BRIDGE_ID_BITS_DEF + mrt_pkg::TIME_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> src/mrt_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module mrt_ctrl #(
    parameter int TABLE_ENTRIES  = mrt_pkg::TABLE_ENTRIES_DEF,
    parameter int BRIDGE_ID_BITS = mrt_pkg::BRIDGE_ID_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [mrt_pkg::S_DATA_W-1:0]          s_axis_tdata,
    input  wire logic [mrt_pkg::CMD_W-1:0]             s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic      [mrt_pkg::M_DATA_W-1:0]          m_axis_tdata,
    output logic                                       o_mem_wr_en,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]      o_mem_wr_addr,
    output logic      [1+mrt_pkg::MAC_W+BRIDGE_ID_BITS+mrt_pkg::TIME_W-1:0] o_mem_wr_data,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]      o_mem_rd_addr,
    input  wire logic [1+mrt_pkg::MAC_W+BRIDGE_ID_BITS+mrt_pkg::TIME_W-1:0] i_mem_rd_data
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int KB    = BRIDGE_ID_BITS;
    localparam int WW    = 1 + mrt_pkg::MAC_W + KB + mrt_pkg::TIME_W;
    localparam int EXT_W = (KB > mrt_pkg::BRIDGE_W) ? KB : mrt_pkg::BRIDGE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state                             r_state, n_state;
    logic [AW-1:0]                      r_rd_addr, n_rd_addr;
    logic [AW-1:0]                      r_eval_addr, n_eval_addr;
    logic                               r_issue_done, n_issue_done;
    logic                               r_rd_pend, n_rd_pend;
    mrt_pkg::t_cmd                      r_cmd, n_cmd;
    logic [mrt_pkg::MAC_W-1:0]          r_mac, n_mac;
    logic [KB-1:0]                      r_bridge, n_bridge;
    logic [mrt_pkg::TIME_W-1:0]         r_expiry, n_expiry;
    logic [mrt_pkg::TIME_W-1:0]         r_now, n_now;
    logic                               r_hit, n_hit;
    logic [AW-1:0]                      r_match_idx, n_match_idx;
    logic                               r_free_found, n_free_found;
    logic [AW-1:0]                      r_free_idx, n_free_idx;
    logic [mrt_pkg::TIME_W-1:0]         r_stored, n_stored;
    logic [mrt_pkg::CNT_W-1:0]          r_removed, n_removed;
    logic                               r_out_valid, n_out_valid;
    logic [mrt_pkg::M_DATA_W-1:0]       r_out_data, n_out_data;

    logic                               rd_valid;
    logic [mrt_pkg::MAC_W-1:0]          rd_mac;
    logic [KB-1:0]                      rd_bridge;
    logic [mrt_pkg::TIME_W-1:0]         rd_expiry;
    logic [EXT_W-1:0]                   in_bridge_ext;
    logic                               rd_match;
    logic                               out_load;
    logic                               res_hit;
    logic                               res_dropped;
    logic [mrt_pkg::TIME_W-1:0]         res_stored;

    assign rd_valid  = i_mem_rd_data[WW-1];
    assign rd_mac    = i_mem_rd_data[WW-2 -: mrt_pkg::MAC_W];
    assign rd_bridge = i_mem_rd_data[mrt_pkg::TIME_W +: KB];
    assign rd_expiry = i_mem_rd_data[mrt_pkg::TIME_W-1:0];
    assign rd_match  = rd_valid && (rd_mac == r_mac) && (rd_bridge == r_bridge);

    assign in_bridge_ext = EXT_W'(s_axis_tdata[mrt_pkg::MAC_W +: mrt_pkg::BRIDGE_W]);
    assign out_load      = !r_out_valid || m_axis_tready;

    assign res_hit     = ((r_cmd == mrt_pkg::CMD_LOOKUP) || (r_cmd == mrt_pkg::CMD_INSERT))
                         && r_hit;
    assign res_stored  = ((r_cmd == mrt_pkg::CMD_LOOKUP) && r_hit) ? r_stored : '0;
    assign res_dropped = (r_cmd == mrt_pkg::CMD_INSERT) && !r_hit && !r_free_found;

    always_comb begin
        n_state      = r_state;
        n_rd_addr    = r_rd_addr;
        n_eval_addr  = r_eval_addr;
        n_issue_done = r_issue_done;
        n_rd_pend    = r_rd_pend;
        n_cmd        = r_cmd;
        n_mac        = r_mac;
        n_bridge     = r_bridge;
        n_expiry     = r_expiry;
        n_now        = r_now;
        n_hit        = r_hit;
        n_match_idx  = r_match_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_stored     = r_stored;
        n_removed    = r_removed;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_eval_addr;
        o_mem_wr_data = {1'b0, rd_mac, rd_bridge, rd_expiry};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_rd_addr;
                o_mem_wr_data = '0;
                if (r_rd_addr == LAST_ADDR) begin
                    n_rd_addr = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd        = mrt_pkg::t_cmd'(s_axis_tuser);
                    n_mac        = s_axis_tdata[mrt_pkg::MAC_W-1:0];
                    n_bridge     = in_bridge_ext[KB-1:0];
                    n_expiry     = s_axis_tdata[56 +: mrt_pkg::TIME_W];
                    n_now        = s_axis_tdata[88 +: mrt_pkg::TIME_W];
                    n_rd_addr    = '0;
                    n_issue_done = 1'b0;
                    n_rd_pend    = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_stored     = '0;
                    n_removed    = '0;
                    if (mrt_pkg::t_cmd'(s_axis_tuser) == mrt_pkg::CMD_NOP) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                n_rd_pend   = !r_issue_done;
                n_eval_addr = r_rd_addr;
                if (!r_issue_done) begin
                    if (r_rd_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end
                if (r_rd_pend) begin
                    if (rd_match && !r_hit) begin
                        n_hit       = 1'b1;
                        n_match_idx = r_eval_addr;
                        if (r_cmd == mrt_pkg::CMD_LOOKUP) begin
                            n_stored = rd_expiry;
                        end
                    end
                    if (!rd_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_eval_addr;
                    end
                    if ((r_cmd == mrt_pkg::CMD_SWEEP) && rd_valid && (rd_expiry < r_now)) begin
                        o_mem_wr_en = 1'b1;
                        if (r_removed != mrt_pkg::CNT_MAX) begin
                            n_removed = r_removed + 1'b1;
                        end
                    end
                    if (r_eval_addr == LAST_ADDR) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_removed, res_dropped, res_stored, res_hit};
                    n_state     = S_IDLE;
                    n_rd_addr   = '0;
                    if ((r_cmd == mrt_pkg::CMD_INSERT) && (r_hit || r_free_found)) begin
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_addr = r_hit ? r_match_idx : r_free_idx;
                        o_mem_wr_data = {1'b1, r_mac, r_bridge, r_expiry};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_rd_addr    <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_addr    <= n_rd_addr;
            r_issue_done <= n_issue_done;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
            r_eval_addr  <= n_eval_addr;
            r_cmd        <= n_cmd;
            r_mac        <= n_mac;
            r_bridge     <= n_bridge;
            r_expiry     <= n_expiry;
            r_now        <= n_now;
            r_hit        <= n_hit;
            r_match_idx  <= n_match_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_stored     <= n_stored;
            r_removed    <= n_removed;
            r_out_data   <= n_out_data;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_mem_rd_addr = r_rd_addr;

    // The table is never written while the block waits for an item.
    `MRT_ASSERT_NEVER(a_idle_no_write, i_clk, i_rst_n,
        (r_state == S_IDLE) && o_mem_wr_en, "table written while idle")
    // During the walk only a sweep writes, clearing the entry it has just read.
    `MRT_ASSERT(a_walk_write_sweep, i_clk, i_rst_n,
        ((r_state == S_WALK) && o_mem_wr_en) |-> (r_cmd == mrt_pkg::CMD_SWEEP),
        "walk write outside sweep")
    // Evaluating the last entry ends the walk.
    `MRT_ASSERT(a_walk_ends, i_clk, i_rst_n,
        ((r_state == S_WALK) && r_rd_pend && (r_eval_addr == LAST_ADDR)) |=>
        (r_state == S_FINISH), "walk did not finish")

endmodule

`default_nettype wire
